/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the identifier allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/bia_pkg.sv */
// ----------------------------------------------------------------------------
// Identifier allocator package
// Sizes, codes and control types shared by the allocator modules.
// ----------------------------------------------------------------------------
package bia_pkg;

    localparam int BITMAP_WORDS = 64;
    localparam int WORD_BITS    = 64;
    localparam int BIT_W        = 6;
    localparam int ID_W         = 12;
    localparam int ACTIVE_WORDS = (BITMAP_WORDS < 64) ? BITMAP_WORDS : 64;
    localparam int WADDR_W      = (ACTIVE_WORDS > 1) ? $clog2(ACTIVE_WORDS) : 1;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
    } t_ctrl_cmd;

    typedef struct packed {
        logic early;
    } t_dp_status;

endpackage

/* design/bia_if.sv */
// ----------------------------------------------------------------------------
// Allocator channel interfaces
// Command and response channels with valid and ready handshake.
// ----------------------------------------------------------------------------
interface bia_cmd_if;
    logic                        valid;
    logic                        ready;
    bia_pkg::t_command           command;
    logic [bia_pkg::ID_W-1:0]    id;

    modport source (output valid, output command, output id, input ready);
    modport sink   (input valid, input command, input id, output ready);
endinterface

interface bia_rsp_if;
    logic                        valid;
    logic                        ready;
    bia_pkg::t_status            status;
    logic [bia_pkg::ID_W-1:0]    allocated_id;

    modport source (output valid, output status, output allocated_id, input ready);
    modport sink   (input valid, input status, input allocated_id, output ready);
endinterface

/* design/bia_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bia_datapath.sv */
// ----------------------------------------------------------------------------
// Allocator datapath
// Summary search, bitmap word read-modify-write and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bia_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bia_pkg::t_ctrl_cmd            i_ctrl,
    output bia_pkg::t_dp_status           o_stat,
    input  bia_pkg::t_command             i_command,
    input  logic [bia_pkg::ID_W-1:0]      i_id,
    output bia_pkg::t_status              o_status,
    output logic [bia_pkg::ID_W-1:0]      o_allocated_id
);

    localparam int AWORDS = bia_pkg::ACTIVE_WORDS;
    localparam int WB     = bia_pkg::WORD_BITS;
    localparam int AW     = bia_pkg::WADDR_W;

    function automatic logic [bia_pkg::BIT_W-1:0] lowest_zero(input logic [WB-1:0] v);
        logic [bia_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = bia_pkg::BIT_W'(i);
            end
        end
        return idx;
    endfunction

    bia_pkg::t_command          r_cmd;
    logic [bia_pkg::ID_W-1:0]   r_id;
    logic [AW-1:0]              r_word;
    logic [AWORDS-1:0]          r_valid;
    logic [AWORDS-1:0]          n_valid;
    logic [AWORDS-1:0]          r_full;
    logic [AWORDS-1:0]          n_full;
    bia_pkg::t_status           r_status;
    logic [bia_pkg::ID_W-1:0]   r_alloc_id;

    logic                       free_found;
    logic [AW-1:0]              free_idx;
    logic [bia_pkg::ID_W-bia_pkg::BIT_W-1:0] id_word;
    logic                       id_in_range;
    logic [AW-1:0]              look_word;
    logic                       early;

    logic [WB-1:0]              rdata;
    logic [WB-1:0]              cur;
    logic [bia_pkg::BIT_W-1:0]  bit_free;
    logic [bia_pkg::BIT_W-1:0]  id_bit;
    logic [WB-1:0]              alloc_word;
    logic [WB-1:0]              cleared_word;
    logic                       id_used;
    logic                       we;
    logic [WB-1:0]              wdata;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = AWORDS - 1; i >= 0; i--) begin
            if (!r_full[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    assign id_word     = r_id[bia_pkg::ID_W-1:bia_pkg::BIT_W];
    assign id_in_range = int'(id_word) < AWORDS;
    assign look_word   = (r_cmd == bia_pkg::CMD_ALLOC) ? free_idx : id_word[AW-1:0];
    assign early       = (r_cmd == bia_pkg::CMD_ALLOC) ? !free_found : !id_in_range;
    assign o_stat.early = early;

    assign cur          = r_valid[r_word] ? rdata : '0;
    assign bit_free     = lowest_zero(cur);
    assign id_bit       = r_id[bia_pkg::BIT_W-1:0];
    assign alloc_word   = cur | (WB'(1) << bit_free);
    assign cleared_word = cur & ~(WB'(1) << id_bit);
    assign id_used      = cur[id_bit];
    assign we    = i_ctrl.update && ((r_cmd == bia_pkg::CMD_ALLOC) || id_used);
    assign wdata = (r_cmd == bia_pkg::CMD_ALLOC) ? alloc_word : cleared_word;

    bia_ram #(
        .WIDTH (WB),
        .DEPTH (AWORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_word),
        .i_wdata (wdata),
        .i_re    (i_ctrl.lookup),
        .i_raddr (look_word),
        .o_rdata (rdata)
    );

    always_comb begin
        n_valid = r_valid;
        n_full  = r_full;
        if (we) begin
            n_valid[r_word] = 1'b1;
            n_full[r_word]  = (r_cmd == bia_pkg::CMD_ALLOC) ? (&alloc_word) : 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_full  <= '0;
        end else begin
            r_valid <= n_valid;
            r_full  <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= i_command;
            r_id  <= i_id;
        end
        if (i_ctrl.lookup) begin
            r_word <= look_word;
            if (early) begin
                r_status   <= (r_cmd == bia_pkg::CMD_ALLOC) ? bia_pkg::ST_FULL
                                                            : bia_pkg::ST_INVALID;
                r_alloc_id <= '0;
            end
        end
        if (i_ctrl.update) begin
            if (r_cmd == bia_pkg::CMD_ALLOC) begin
                r_status   <= bia_pkg::ST_OK;
                r_alloc_id <= (bia_pkg::ID_W'(r_word) << bia_pkg::BIT_W)
                              | bia_pkg::ID_W'(bit_free);
            end else begin
                r_status   <= id_used ? bia_pkg::ST_OK : bia_pkg::ST_INVALID;
                r_alloc_id <= '0;
            end
        end
    end

    assign o_status       = r_status;
    assign o_allocated_id = r_alloc_id;

    // A word can only be marked full after it has been written at least once.
    `ASSERT_RST(a_full_has_valid, i_clk, i_rst_n,
        ((r_full & ~r_valid) == '0), "full flag on unwritten word")
    // An allocate that reaches the update step always succeeds.
    `ASSERT_RST(a_alloc_update_ok, i_clk, i_rst_n,
        (i_ctrl.update && r_cmd == bia_pkg::CMD_ALLOC |=> r_status == bia_pkg::ST_OK),
        "allocate update did not succeed")

endmodule

/* design/bia_ctrl.sv */
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences accept, lookup, update and response for one transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bia_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  bia_pkg::t_dp_status  i_stat,
    output bia_pkg::t_ctrl_cmd   o_ctrl
);

    bia_pkg::t_state r_state;
    bia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl      = '0;
        unique case (r_state)
            bia_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = bia_pkg::S_LOOKUP;
                end
            end
            bia_pkg::S_LOOKUP: begin
                o_ctrl.lookup = 1'b1;
                n_state = i_stat.early ? bia_pkg::S_RESP : bia_pkg::S_UPDATE;
            end
            bia_pkg::S_UPDATE: begin
                o_ctrl.update = 1'b1;
                n_state = bia_pkg::S_RESP;
            end
            bia_pkg::S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = bia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bia_pkg::S_IDLE;
            end
        endcase
    end

    // Only one transaction is in flight, so both sides are never open together.
    `ASSERT_ALWAYS(a_one_in_flight, i_clk, (!(o_in_ready && o_out_valid)), "input and output open together")
    // A lookup always directly follows an accepted command.
    `ASSERT_RST(a_lookup_after_load, i_clk, i_rst_n, (o_ctrl.lookup |-> $past(o_ctrl.load)), "lookup without accepted command")

endmodule

/* design/bitmap_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// Bitmap identifier allocator
// Grants the lowest free identifier or frees a given one over a bitmap.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload                        Handshake
//   i_cmd     in          command, id                    valid / ready
//   o_rsp     out         status, allocated_id           valid / ready
//
// After acceptance a transaction steps through the lookup, update and response
// states, skipping update if an allocate finds all words full or a free names
// a word out of range; the steps follow the registered bitmap RAM read and its
// write-back. One transaction is handled at a time; a new command is accepted
// in the cycle after the response is taken. The used bitmap starts cleared
// after reset through per-word valid bits, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_id_allocator_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bia_cmd_if.sink   i_cmd,
    bia_rsp_if.source o_rsp
);

    bia_pkg::t_ctrl_cmd  ctrl;
    bia_pkg::t_dp_status stat;
    logic                in_ready;
    logic                out_valid;

    bia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    bia_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .o_stat         (stat),
        .i_command      (i_cmd.command),
        .i_id           (i_cmd.id),
        .o_status       (o_rsp.status),
        .o_allocated_id (o_rsp.allocated_id)
    );

    assign i_cmd.ready = in_ready;
    assign o_rsp.valid = out_valid;

endmodule

/* verif/tb_bitmap_id_allocator_top.sv */
// ----------------------------------------------------------------------------
// Identifier allocator testbench
// Drives allocate and free commands through the command channel and checks
// each response against a bitmap model kept in the bench. A directed table
// covers the edge cases, including a full bitmap. A random phase then frees
// and reallocates identifiers. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_bitmap_id_allocator_top;
    import bia_pkg::*;

    localparam int ID_COUNT     = ACTIVE_WORDS * WORD_BITS;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 150;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 12;
    localparam int ROW_COUNT    = 25;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] allocated_id;
    } t_reply;

    typedef struct {
        t_command        command;
        logic [ID_W-1:0] id;
        bit              fill_first;
        bit              typed;
        t_reply          reply;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bia_cmd_if cmd_if ();
    bia_rsp_if rsp_if ();

    bitmap_id_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    logic [WORD_BITS-1:0]    used_map [ACTIVE_WORDS];
    logic [ACTIVE_WORDS-1:0] full_words;
    int                      ids_in_use;

    t_reply reply_q [$];
    int     fail_count   = 0;
    int     cycle_count  = 0;
    bit     quiet        = 1'b0;
    bit     hold_request = 1'b0;

    // A fill row first allocates until every identifier is in use.
    t_row directed_rows [ROW_COUNT] = '{
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b1, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'hFFF,  1'b0, 1'b1, '{ST_OK,      12'd1}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b1, '{ST_OK,      12'd2}},
        '{CMD_FREE,  12'd1,    1'b0, 1'b1, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd1,    1'b0, 1'b1, '{ST_INVALID, 12'd0}},
        '{CMD_FREE,  12'd4095, 1'b0, 1'b1, '{ST_INVALID, 12'd0}},
        '{CMD_FREE,  12'hAAA,  1'b0, 1'b1, '{ST_INVALID, 12'd0}},
        '{CMD_FREE,  12'h555,  1'b0, 1'b1, '{ST_INVALID, 12'd0}},
        '{CMD_ALLOC, 12'h555,  1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'hAAA,  1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd0,    1'b0, 1'b1, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd2,    1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b1, 1'b1, '{ST_FULL,    12'd0}},
        '{CMD_FREE,  12'd4095, 1'b0, 1'b1, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b1, '{ST_OK,      12'd4095}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b1, '{ST_FULL,    12'd0}},
        '{CMD_FREE,  12'd0,    1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd2048, 1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd64,   1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'd64,   1'b0, 1'b1, '{ST_INVALID, 12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_FREE,  12'hFC0,  1'b0, 1'b0, '{ST_OK,      12'd0}},
        '{CMD_ALLOC, 12'd0,    1'b0, 1'b0, '{ST_OK,      12'd0}}
    };

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_reply update_bitmap(t_command command, logic [ID_W-1:0] id);
        t_reply reply;
        int     word;
        int     bit_idx;
        bit     found;
        reply.status       = ST_OK;
        reply.allocated_id = '0;
        found              = 1'b0;
        word               = 0;
        if (command == CMD_ALLOC) begin
            for (int w = 0; w < ACTIVE_WORDS && !found; w++) begin
                if (!full_words[w]) begin
                    word  = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                reply.status = ST_FULL;
            end else begin
                bit_idx = 0;
                while (used_map[word][bit_idx]) bit_idx++;
                used_map[word][bit_idx] = 1'b1;
                if (&used_map[word]) full_words[word] = 1'b1;
                reply.allocated_id = ID_W'(word * WORD_BITS + bit_idx);
                ids_in_use++;
            end
        end else begin
            word    = int'(id >> BIT_W);
            bit_idx = int'(id[BIT_W-1:0]);
            if (word >= ACTIVE_WORDS || !used_map[word][bit_idx]) begin
                reply.status = ST_INVALID;
            end else begin
                used_map[word][bit_idx] = 1'b0;
                full_words[word]        = 1'b0;
                ids_in_use--;
            end
        end
        return reply;
    endfunction

    function automatic logic [ID_W-1:0] used_id_from(logic [ID_W-1:0] start);
        logic [ID_W-1:0] id;
        id = start;
        repeat (ID_COUNT) begin
            if (used_map[id >> BIT_W][id[BIT_W-1:0]]) return id;
            id++;
        end
        return start;
    endfunction

    task automatic send_command(t_command command, logic [ID_W-1:0] id,
                                bit typed = 1'b0, t_reply typed_reply = '0);
        t_reply predicted;
        cmd_if.valid   <= 1'b1;
        cmd_if.command <= command;
        cmd_if.id      <= id;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = update_bitmap(command, id);
        reply_q.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic sender_gap();
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 8);
            cmd_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin : receiver
        int n;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_if.ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : response_check
        t_reply want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (reply_q.size() == 0) begin
                $error("response transaction with nothing outstanding");
                fail_count++;
            end else begin
                want = reply_q.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.allocated_id !== want.allocated_id) begin
                    $error("allocated_id: expected %0d, actual %0d",
                           want.allocated_id, rsp_if.allocated_id);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        int              pick;
        t_command        command;
        logic [ID_W-1:0] id;
        i_rst_n        <= 1'b0;
        cmd_if.valid   <= 1'b0;
        cmd_if.command <= CMD_ALLOC;
        cmd_if.id      <= '0;
        foreach (used_map[w]) used_map[w] = '0;
        full_words = '0;
        ids_in_use = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].fill_first) begin
                hold_request = 1'b1;
                while (ids_in_use < ID_COUNT) begin
                    sender_gap();
                    send_command(CMD_ALLOC, ID_W'($urandom));
                end
            end
            sender_gap();
            send_command(directed_rows[i].command, directed_rows[i].id,
                         directed_rows[i].typed, directed_rows[i].reply);
        end

        cmd_if.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // Mostly frees of live identifiers first, then mostly allocations so the
        // bitmap fills up again.
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            quiet = (k >= RANDOM_ITEMS - QUIET_ITEMS);
            pick  = $urandom_range(0, 99);
            id    = ID_W'($urandom);
            if (k < RANDOM_ITEMS / 2) begin
                if (pick < 30) begin
                    command = CMD_ALLOC;
                end else begin
                    command = CMD_FREE;
                    if (pick < 85) id = used_id_from(id);
                end
            end else begin
                if (pick < 70) begin
                    command = CMD_ALLOC;
                end else begin
                    command = CMD_FREE;
                    if (pick < 90) id = used_id_from(id);
                end
            end
            sender_gap();
            send_command(command, id);
        end

        cmd_if.valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
